@@ hw/rtl/pbd_pkg.sv @@
// Shared types and constants of the pulse beat detector.
`default_nettype none
package pbd_pkg;
   localparam int STATE_W = 24;
   localparam int COEF_W  = 16;
   localparam int CNT_W   = 16;
   localparam logic [16:0] C_ONE       = 17'd65536;
   localparam logic [16:0] C_HP        = 17'd62259;
   localparam logic [16:0] C_LP_NEW    = 17'd13107;
   localparam logic [16:0] C_LP_OLD    = 17'd52429;
   localparam logic [16:0] C_FLOOR_ATK = 17'd62259;
   localparam logic [16:0] C_FLOOR_DEC = 17'd65470;
   localparam logic [16:0] C_CEIL_ATK  = 17'd58982;
   localparam logic [16:0] C_CEIL_DEC  = 17'd65503;
   localparam logic [23:0] RATE_NUM2   = 24'd12288000;
   localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

   localparam logic [2:0] REG_MIN_SWING  = 3'd0;
   localparam logic [2:0] REG_REFRACTORY = 3'd1;
   localparam logic [2:0] REG_IVL_MIN    = 3'd2;
   localparam logic [2:0] REG_IVL_MAX    = 3'd3;
   localparam logic [2:0] REG_TRIG_FRAC  = 3'd4;
   localparam logic [2:0] REG_RATE_MIN   = 3'd5;
   localparam logic [2:0] REG_RATE_MAX   = 3'd6;

   // Candidate handed from the filter front to the beat back end.
   typedef struct packed {
      logic        ok;
      logic        cand;
      logic [15:0] count;
   } cand_type;

   typedef enum logic [3:0] {
      F_IDLE, F_HP, F_LP, F_FL0, F_FL1, F_CE0, F_CE1, F_SWING, F_TRIG, F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {B_IDLE, B_DIV, B_AVG, B_OUT} back_state_type;

   // round to nearest, ties up, then saturate to 24 bits
   function automatic logic signed [23:0] round_sat(input logic signed [47:0] v);
      logic signed [47:0] t;
      logic signed [31:0] q;
      begin
         t = v + 48'sd32768;
         q = t[47:16];
         if (q > 32'sd8388607) round_sat = 24'sh7FFFFF;
         else if (q < -32'sd8388608) round_sat = 24'sh800000;
         else round_sat = q[23:0];
      end
   endfunction
endpackage
`default_nettype wire

@@ hw/rtl/pbd_front.sv @@
// Front: filters, level trackers, peak window and candidate classification.
`default_nettype none
module pbd_front
   import pbd_pkg::*;
#(
   parameter int PEAK_SPAN = 5,
   parameter int SAMPLE_BITS = 12,
   parameter int FRAC_BITS = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire logic [SAMPLE_BITS-1:0] in_sample,
   input  wire logic [11:0]            min_swing,
   input  wire logic [8:0]             trig_frac,
   input  wire logic                   restart,
   output logic                        q_valid,
   input  wire logic                   q_ready,
   output cand_type                    q_data
);
   front_state_type state_ff, state_in;
   logic [SAMPLE_BITS-1:0] last_ff;
   logic signed [23:0] hp_ff, lp_ff, fl_ff, ce_ff, swing_ff;
   logic signed [23:0] win_ff [PEAK_SPAN];
   logic [15:0] cnt_ff;
   logic ok_ff;
   logic signed [47:0] acc_ff, acc_in;
   logic signed [24:0] mop_a, mop_b;
   logic [16:0] mco;
   logic signed [47:0] prod;
   logic signed [23:0] res;
   logic peak, thr_ok;
   logic signed [35:0] lhs, rhs;

   assign in_ready = (state_ff == F_IDLE);
   assign q_data = '{ok: ok_ff, cand: peak && thr_ok && ok_ff, count: cnt_ff};
   assign q_valid = (state_ff == F_PUSH);
   assign res = round_sat(acc_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE:  if (in_valid) state_in = F_HP;
         F_HP:    state_in = F_LP;
         F_LP:    state_in = F_FL0;
         F_FL0:   state_in = F_FL1;
         F_FL1:   state_in = F_CE0;
         F_CE0:   state_in = F_CE1;
         F_CE1:   state_in = F_SWING;
         F_SWING: state_in = F_TRIG;
         F_TRIG:  state_in = F_PUSH;
         F_PUSH:  if (q_ready) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   // one multiply-add per step
   always_comb begin
      mop_a = '0; mop_b = '0; mco = '0;
      case (state_ff)
         F_IDLE: begin
            mop_a = 25'(hp_ff) + 25'(signed'({1'b0, in_sample, FRAC_BITS'(0)}))
                  - 25'(signed'({1'b0, last_ff, FRAC_BITS'(0)}));
            mco = C_HP;
         end
         F_HP: begin mop_a = 25'(res); mco = C_LP_NEW; end
         F_LP: begin mop_a = 25'(lp_ff); mco = C_LP_OLD; end
         F_FL0: begin
            // new low-pass value is still on the rounder output here
            mop_a = 25'(fl_ff);
            mco = (res < fl_ff) ? C_FLOOR_ATK : C_FLOOR_DEC;
         end
         F_FL1: begin
            mop_a = 25'(lp_ff);
            mco = C_ONE - ((lp_ff < fl_ff) ? C_FLOOR_ATK : C_FLOOR_DEC);
         end
         F_CE0: begin
            mop_a = 25'(ce_ff);
            mco = (lp_ff > ce_ff) ? C_CEIL_ATK : C_CEIL_DEC;
         end
         F_CE1: begin
            mop_a = 25'(lp_ff);
            mco = C_ONE - ((lp_ff > ce_ff) ? C_CEIL_ATK : C_CEIL_DEC);
         end
         default: ;
      endcase
      mop_b = mop_a;
      prod = 48'(mop_b) * 48'(signed'({1'b0, mco}));
   end

   always_comb begin
      acc_in = acc_ff;
      case (state_ff)
         F_IDLE: acc_in = prod;
         F_HP: acc_in = prod;
         F_LP: acc_in = acc_ff + prod;
         F_FL0: acc_in = prod;
         F_FL1: acc_in = acc_ff + prod;
         F_CE0: acc_in = prod;
         F_CE1: acc_in = acc_ff + prod;
         default: ;
      endcase
   end

   always_comb begin
      peak = 1'b1;
      for (int i = 0; i < PEAK_SPAN; i++)
         if (i != PEAK_SPAN / 2 && win_ff[i] >= win_ff[PEAK_SPAN / 2]) peak = 1'b0;
      lhs = 36'(win_ff[PEAK_SPAN / 2]) <<< 8;
      rhs = (36'(fl_ff) <<< 8) + 36'(swing_ff) * 36'(signed'({1'b0, trig_frac}));
      thr_ok = lhs > rhs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         last_ff <= '0; hp_ff <= '0; lp_ff <= '0;
         fl_ff <= 24'(1 << (SAMPLE_BITS - 1 + FRAC_BITS));
         ce_ff <= 24'(1 << (SAMPLE_BITS - 1 + FRAC_BITS));
         for (int i = 0; i < PEAK_SPAN; i++) win_ff[i] <= '0;
         cnt_ff <= '0; ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            F_IDLE: if (in_valid) begin
               last_ff <= in_sample;
               if (cnt_ff != COUNT_MAX) cnt_ff <= cnt_ff + 16'd1;
            end
            F_HP: hp_ff <= res;
            F_FL0: lp_ff <= res;
            F_CE0: fl_ff <= res;
            F_SWING: begin
               ce_ff <= res;
               for (int i = PEAK_SPAN - 1; i > 0; i--) win_ff[i] <= win_ff[i - 1];
               win_ff[0] <= lp_ff;
            end
            F_TRIG: ok_ff <= swing_ff >= 24'(signed'({1'b0, min_swing, FRAC_BITS'(0)}));
            // restart the count once the back end takes a candidate past refractory
            F_PUSH: if (restart) cnt_ff <= '0;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (state_ff == F_SWING) swing_ff <= res - fl_ff;
   end
endmodule
`default_nettype wire

@@ hw/rtl/pbd_back.sv @@
// Back: refractory and interval checks, rate division, averaging, result register.
`default_nettype none
module pbd_back
   import pbd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_valid,
   output logic             q_ready,
   input  cand_type         q_data,
   input  wire logic [9:0]  refr,
   input  wire logic [11:0] ivl_min,
   input  wire logic [11:0] ivl_max,
   input  wire logic [7:0]  rate_min,
   input  wire logic [7:0]  rate_max,
   output logic             restart,
   output logic             out_valid,
   input  wire logic        out_ready,
   output logic [45:0]      out_data
);
   back_state_type state_ff, state_in;
   logic [23:0] rem_ff, rem_in;
   logic [16:0] den_ff;
   logic [24:0] quo_ff, quo_in;
   logic [4:0]  step_ff;
   logic ok_ff, beat_ff, vld_ff;
   logic [11:0] ivl_ff;
   logic [15:0] avg_ff, rnow_ff;
   logic [18:0] twice;
   logic accept_beat, past_refr;
   logic [24:0] rshift;
   logic [15:0] rsat;
   logic [33:0] asum;

   assign twice = 19'(q_data.count) * 19'd5;
   assign past_refr = q_data.cand && (q_data.count > 16'(refr));
   assign accept_beat = past_refr && (twice > {6'd0, ivl_min, 1'b0})
                        && (twice < {6'd0, ivl_max, 1'b0});
   assign q_ready = (state_ff == B_IDLE) && (!vld_ff || out_ready);
   assign restart = q_valid && q_ready && past_refr;
   assign out_valid = vld_ff;
   assign out_data = {avg_ff, rnow_ff, ivl_ff, beat_ff, ok_ff};

   // restoring divide, one quotient bit per cycle
   assign rshift = {rem_ff, quo_ff[24]};
   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff;
      if (rshift >= 25'(den_ff)) begin
         rem_in = 24'(rshift - 25'(den_ff));
         quo_in = {quo_ff[23:0], 1'b1};
      end else begin
         rem_in = rshift[23:0];
         quo_in = {quo_ff[23:0], 1'b0};
      end
   end

   assign rsat = (|quo_ff[24:16]) ? 16'hFFFF : quo_ff[15:0];
   assign asum = 34'(C_LP_OLD) * 34'(avg_ff) + 34'(C_LP_NEW) * 34'(quo_ff) + 34'd32768;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: if (q_valid && q_ready) state_in = accept_beat ? B_DIV : B_OUT;
         B_DIV:  if (step_ff == 5'd24) state_in = B_AVG;
         B_AVG:  state_in = B_OUT;
         B_OUT:  state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE; vld_ff <= 1'b0; avg_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (vld_ff && out_ready) vld_ff <= 1'b0;
         if (state_ff == B_OUT) vld_ff <= 1'b1;
         if (state_ff == B_AVG && quo_ff > {9'd0, rate_min, 8'd0}
             && quo_ff < {9'd0, rate_max, 8'd0})
            avg_ff <= asum[31:16];
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         // capture only on a transfer so a waiting result holds
         B_IDLE: if (q_valid && q_ready) begin
            ok_ff <= q_data.ok; beat_ff <= accept_beat;
            ivl_ff <= accept_beat ? twice[12:1] : 12'd0;
            rnow_ff <= '0;
            den_ff <= {q_data.count, 1'b0};
            quo_ff <= {1'b0, RATE_NUM2 + 24'(q_data.count)};
            rem_ff <= '0; step_ff <= '0;
         end
         B_DIV: begin
            rem_ff <= rem_in; quo_ff <= quo_in; step_ff <= step_ff + 5'd1;
         end
         B_AVG: rnow_ff <= rsat;
         default: ;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset) restart |-> q_data.cand)
      else $error("restart without candidate");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV) |-> !q_ready) else $error("ready during divide");
   assert property (@(posedge clock) disable iff (reset)
      (vld_ff && !out_ready) |=> $stable(out_data)) else $error("result changed");
endmodule
`default_nettype wire

@@ hw/rtl/ppg_beat_detector.sv @@
// Top level of the pulse beat detector.
// The front takes a new sample only once it has handed the last one on. When the
// sample passes the beat checks, its result waits for the 25-step restoring divider
// for the rate before it reaches the output register. The filter front runs one
// shared 25x17 multiplier over seven steps and hands a candidate to the beat back
// end through a one-entry hand-off, so the front filters the next sample while the
// divider runs or a result waits at the output register.
`default_nettype none
module ppg_beat_detector
   import pbd_pkg::*;
#(
   parameter int PEAK_SPAN = 5,
   parameter int SAMPLE_BITS = 12,
   parameter int FRAC_BITS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // sample
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // signal_ok, beat, interval_ms, rate_now, rate_smoothed
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [11:0] csr_wdata
);
   logic [11:0] min_swing_ff, ivl_min_ff, ivl_max_ff;
   logic [9:0] refr_ff;
   logic [8:0] trig_ff;
   logic [7:0] rmin_ff, rmax_ff;
   logic q_valid, q_ready, restart;
   cand_type q_data, q_fix;
   logic [45:0] out_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_swing_ff <= 12'd200; refr_ff <= 10'd80; ivl_min_ff <= 12'd300;
         ivl_max_ff <= 12'd1500; trig_ff <= 9'd141; rmin_ff <= 8'd40; rmax_ff <= 8'd180;
      end else if (csr_we) begin
         case (csr_index)
            REG_MIN_SWING:  min_swing_ff <= csr_wdata;
            REG_REFRACTORY: refr_ff <= csr_wdata[9:0];
            REG_IVL_MIN:    ivl_min_ff <= csr_wdata;
            REG_IVL_MAX:    ivl_max_ff <= csr_wdata;
            REG_TRIG_FRAC:  trig_ff <= csr_wdata[8:0];
            REG_RATE_MIN:   rmin_ff <= csr_wdata[7:0];
            REG_RATE_MAX:   rmax_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   pbd_front #(.PEAK_SPAN(PEAK_SPAN), .SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_sample(req_tdata[SAMPLE_BITS-1:0]), .min_swing(min_swing_ff), .trig_frac(trig_ff),
      .restart, .q_valid, .q_ready, .q_data
   );

   assign q_fix = q_data;

   pbd_back u_back (
      .clock, .reset, .q_valid, .q_ready, .q_data(q_fix), .refr(refr_ff),
      .ivl_min(ivl_min_ff), .ivl_max(ivl_max_ff), .rate_min(rmin_ff), .rate_max(rmax_ff),
      .restart, .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data
   );

   assign rsp_tdata = {2'b00, out_data};

   // the count restart happens only on a hand-off transfer
   assert property (@(posedge clock) disable iff (reset)
      restart |-> q_valid) else $error("restart outside transfer");
endmodule
`default_nettype wire
